// ===== rtl/tfd_pkg.sv =====
`timescale 1ns / 1ps

package tfd_pkg;

  // Window of stack readings and the part of it that the spread check covers.
  localparam int unsigned WIN_DEPTH  = 10;
  localparam int unsigned SPAN_COUNT = 8;
  localparam int unsigned FILL_W     = $clog2(WIN_DEPTH + 1);
  localparam int unsigned SPAN_IDX_W = $clog2(SPAN_COUNT);

  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned DEG_W    = 12;
  localparam int unsigned OPND_W   = 18;
  localparam int unsigned DIFF_W   = OPND_W + 1;

  localparam logic [4:0] SETTLE_TARGET = 5'd20;
  localparam logic signed [TEMP_W-1:0] NEAR_ZERO_UNITS = 16'sd80;
  localparam logic signed [10:0] SETPOINT_MARGIN = 11'sd5;
  localparam logic [7:0] MIN_START_TEMP = 8'd10;
  localparam logic [7:0] LIMIT_RESET = 8'd20;

  localparam logic [1:0] BIT_GOOD     = 2'b01;
  localparam logic [1:0] BIT_NOT_GOOD = 2'b10;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_VARIATION_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_SETPOINT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_TEMP    = 2'd2;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [DEG_W-1:0]  deg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_LOAD,
    ST_MIN,
    ST_MAX,
    ST_SPAN,
    ST_OVER,
    ST_D89,
    ST_C89,
    ST_D86,
    ST_C86,
    ST_PROC,
    ST_FIN
  } state_t;

  // Operands for the shared subtractor.
  typedef struct packed {
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
  } alu_req_t;

  // What the subtractor hands back.
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        absval;
    logic                     lt;
  } alu_rsp_t;

  // Fixed taps of the newest window entries.
  typedef struct packed {
    temp_t w6;
    temp_t w7;
    temp_t w8;
    temp_t w9;
  } taps_t;

  // Whole degrees, truncated toward zero.
  function automatic deg_t trunc_deg(input temp_t t);
    logic signed [TEMP_W:0] biased;
    logic signed [TEMP_W:0] shifted;
    biased  = t[TEMP_W-1] ? ($signed({t[TEMP_W-1], t}) + 17'sd15) :
                            $signed({t[TEMP_W-1], t});
    shifted = biased >>> 4;
    return shifted[DEG_W-1:0];
  endfunction

endpackage

// ===== rtl/tfd_alu.sv =====
`timescale 1ns / 1ps

// Shared subtractor: difference, its magnitude and the less-than flag.
module tfd_alu (
  input  tfd_pkg::alu_req_t req,
  output tfd_pkg::alu_rsp_t rsp
);

  logic signed [tfd_pkg::DIFF_W-1:0] diff;

  assign diff = $signed({req.a[tfd_pkg::OPND_W-1], req.a}) -
                $signed({req.b[tfd_pkg::OPND_W-1], req.b});

  assign rsp.diff   = diff;
  assign rsp.lt     = diff[tfd_pkg::DIFF_W-1];
  assign rsp.absval = diff[tfd_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;

endmodule

// ===== rtl/tfd_window.sv =====
`timescale 1ns / 1ps

// Ten-entry window of stack readings: fills in order, then shifts toward entry 0.
module tfd_window (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 wr_en,
  input  tfd_pkg::temp_t                       wr_data,
  input  logic [tfd_pkg::SPAN_IDX_W-1:0]       rd_idx,
  output tfd_pkg::temp_t                       rd_data,
  output tfd_pkg::taps_t                       taps,
  output logic                                 full
);

  tfd_pkg::temp_t                 win_r [tfd_pkg::WIN_DEPTH];
  logic [tfd_pkg::FILL_W-1:0]     fill_r;
  logic [tfd_pkg::FILL_W-1:0]     fill_nxt;

  assign full = (fill_r >= tfd_pkg::FILL_W'(tfd_pkg::WIN_DEPTH));

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && !full) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (full) begin
        for (int k = 0; k < tfd_pkg::WIN_DEPTH - 1; k++) begin
          win_r[k] <= win_r[k+1];
        end
        win_r[tfd_pkg::WIN_DEPTH-1] <= wr_data;
      end else begin
        win_r[fill_r] <= wr_data;
      end
    end
  end

  assign rd_data = win_r[{1'b0, rd_idx}];
  assign taps.w6 = win_r[6];
  assign taps.w7 = win_r[7];
  assign taps.w8 = win_r[8];
  assign taps.w9 = win_r[9];

endmodule

// ===== rtl/thermocouple_fault_detector_unit.sv =====
`timescale 1ns / 1ps

// A sample is accepted only while the sequencer is idle, so a new one waits until
// the last has committed its result. A settled sample runs its compares, two for
// each spread entry after the first, through the single shared subtractor; an
// unsettled one skips to the final step, which a result still waiting holds.
// Reset (rst_n, synchronous, active low) clears the fill and settle counters, the
// forgiveness flag and the fatal bits, and loads the registers with their defaults.
module thermocouple_fault_detector_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel. tdata from bit 0: stack_temp[15:0], processor_temp[31:16],
  // plant_off[32], plant_good[33], zeros[39:34].
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,
  // Result channel. tdata from bit 0: fault_now[0], persist_request[1],
  // fatal_flags[3:2], transient_forgiven[4], zeros[7:5].
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers.
  logic [7:0] limit_r;
  logic [9:0] setpoint_r;
  logic [7:0] start_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= tfd_pkg::LIMIT_RESET;
      setpoint_r <= '0;
      start_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tfd_pkg::REG_VARIATION_LIMIT: limit_r    <= cfg_data[7:0];
        tfd_pkg::REG_PROC_SETPOINT:   setpoint_r <= cfg_data;
        tfd_pkg::REG_STARTUP_TEMP:    start_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The processor threshold only follows the setpoint, so it is derived here once.
  logic signed [10:0] sp_less;
  logic signed [14:0] proc_thr;
  assign sp_less  = $signed({1'b0, setpoint_r}) - tfd_pkg::SETPOINT_MARGIN;
  assign proc_thr = {sp_less, 4'b0000};

  // Sequencer state and working registers.
  tfd_pkg::state_t state_r, state_nxt;

  tfd_pkg::temp_t stack_r, stack_nxt;
  tfd_pkg::temp_t proc_r, proc_nxt;
  logic           off_r, off_nxt;
  logic           good_r, good_nxt;

  logic [4:0]     settle_r, settle_nxt;
  logic           settled_r, settled_nxt;
  logic [tfd_pkg::SPAN_IDX_W-1:0] idx_r, idx_nxt;
  tfd_pkg::deg_t  lo_r, lo_nxt;
  tfd_pkg::deg_t  hi_r, hi_nxt;
  logic [12:0]    span_r, span_nxt;
  logic           over_r, over_nxt;
  logic [16:0]    abs_r, abs_nxt;
  logic           ok89_r, ok89_nxt;
  logic           ok86_r, ok86_nxt;
  logic           proc_ok_r, proc_ok_nxt;

  logic [1:0]     fatal_r, fatal_nxt;
  logic           forgive_r, forgive_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [4:0]     out_r, out_nxt;

  // Window and shared unit.
  logic           win_wr;
  tfd_pkg::temp_t win_rd;
  tfd_pkg::taps_t taps;
  logic           win_full;
  tfd_pkg::deg_t  rd_deg;

  tfd_pkg::alu_req_t alu_req;
  tfd_pkg::alu_rsp_t alu_rsp;

  tfd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (win_wr),
    .wr_data (stack_r),
    .rd_idx  (idx_r),
    .rd_data (win_rd),
    .taps    (taps),
    .full    (win_full)
  );

  tfd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign rd_deg = tfd_pkg::trunc_deg(win_rd);

  // The result register frees up when its transfer completes.
  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == tfd_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r};

  // Working values of the decision step.
  logic [1:0] sel;
  logic [1:0] f_fin;
  logic       fl_fin;
  logic       fault_fin;
  logic       pers_fin;
  logic       near_zero;
  logic [4:0] settle_base;

  always_comb begin
    state_nxt   = state_r;
    stack_nxt   = stack_r;
    proc_nxt    = proc_r;
    off_nxt     = off_r;
    good_nxt    = good_r;
    settle_nxt  = settle_r;
    settled_nxt = settled_r;
    idx_nxt     = idx_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    span_nxt    = span_r;
    over_nxt    = over_r;
    abs_nxt     = abs_r;
    ok89_nxt    = ok89_r;
    ok86_nxt    = ok86_r;
    proc_ok_nxt = proc_ok_r;
    fatal_nxt   = fatal_r;
    forgive_nxt = forgive_r;
    out_nxt     = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    win_wr      = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;

    sel       = good_r ? tfd_pkg::BIT_GOOD : tfd_pkg::BIT_NOT_GOOD;
    f_fin     = fatal_r;
    fl_fin    = forgive_r;
    fault_fin = 1'b0;
    pers_fin  = 1'b0;
    settle_base = off_r ? 5'd0 : settle_r;

    near_zero = (stack_r <= tfd_pkg::NEAR_ZERO_UNITS) &&
                (taps.w6 <= tfd_pkg::NEAR_ZERO_UNITS) &&
                (taps.w7 <= tfd_pkg::NEAR_ZERO_UNITS) &&
                (taps.w8 <= tfd_pkg::NEAR_ZERO_UNITS) &&
                (taps.w9 <= tfd_pkg::NEAR_ZERO_UNITS);

    // Spread check first, then the stuck-sensor check on its outcome.
    if (settled_r) begin
      if (over_r) begin
        if (fl_fin) begin
          fl_fin = 1'b0;
        end else if (ok89_r && ok86_r) begin
          fl_fin = 1'b1;
        end
        if (!fl_fin) begin
          f_fin     = f_fin | sel;
          pers_fin  = 1'b1;
          fault_fin = 1'b1;
        end
      end
      if (proc_ok_r && near_zero && (f_fin == 2'b00) &&
          (start_r > tfd_pkg::MIN_START_TEMP)) begin
        f_fin = f_fin | sel;
        if (!f_fin[1]) begin
          pers_fin = 1'b1;
        end
        fault_fin = 1'b1;
      end
    end

    case (state_r)
      tfd_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          stack_nxt = in_tdata[15:0];
          proc_nxt  = in_tdata[31:16];
          off_nxt   = in_tdata[32];
          good_nxt  = in_tdata[33];
          state_nxt = tfd_pkg::ST_UPD;
        end
      end
      tfd_pkg::ST_UPD: begin
        // Settle only counts on samples that arrive with the window already full.
        win_wr     = 1'b1;
        settle_nxt = settle_base;
        if (win_full && (settle_base < tfd_pkg::SETTLE_TARGET)) begin
          settle_nxt = settle_base + 1'b1;
        end
        settled_nxt = (settle_nxt >= tfd_pkg::SETTLE_TARGET);
        idx_nxt     = '0;
        state_nxt   = settled_nxt ? tfd_pkg::ST_LOAD : tfd_pkg::ST_FIN;
      end
      tfd_pkg::ST_LOAD: begin
        lo_nxt    = rd_deg;
        hi_nxt    = rd_deg;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = tfd_pkg::ST_MIN;
      end
      tfd_pkg::ST_MIN: begin
        alu_req.a = tfd_pkg::OPND_W'(rd_deg);
        alu_req.b = tfd_pkg::OPND_W'(lo_r);
        if (alu_rsp.lt) begin
          lo_nxt = rd_deg;
        end
        state_nxt = tfd_pkg::ST_MAX;
      end
      tfd_pkg::ST_MAX: begin
        alu_req.a = tfd_pkg::OPND_W'(hi_r);
        alu_req.b = tfd_pkg::OPND_W'(rd_deg);
        if (alu_rsp.lt) begin
          hi_nxt = rd_deg;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == tfd_pkg::SPAN_IDX_W'(tfd_pkg::SPAN_COUNT - 1)) begin
          state_nxt = tfd_pkg::ST_SPAN;
        end else begin
          state_nxt = tfd_pkg::ST_MIN;
        end
      end
      tfd_pkg::ST_SPAN: begin
        alu_req.a = tfd_pkg::OPND_W'(hi_r);
        alu_req.b = tfd_pkg::OPND_W'(lo_r);
        span_nxt  = alu_rsp.diff[12:0];
        state_nxt = tfd_pkg::ST_OVER;
      end
      tfd_pkg::ST_OVER: begin
        alu_req.a = tfd_pkg::OPND_W'({1'b0, limit_r});
        alu_req.b = tfd_pkg::OPND_W'({1'b0, span_r});
        over_nxt  = alu_rsp.lt;
        state_nxt = tfd_pkg::ST_D89;
      end
      tfd_pkg::ST_D89: begin
        alu_req.a = tfd_pkg::OPND_W'(taps.w8);
        alu_req.b = tfd_pkg::OPND_W'(taps.w9);
        abs_nxt   = alu_rsp.absval[16:0];
        state_nxt = tfd_pkg::ST_C89;
      end
      tfd_pkg::ST_C89: begin
        alu_req.a = tfd_pkg::OPND_W'({2'b00, limit_r, 1'b0});
        alu_req.b = tfd_pkg::OPND_W'({1'b0, abs_r});
        ok89_nxt  = !alu_rsp.lt;
        state_nxt = tfd_pkg::ST_D86;
      end
      tfd_pkg::ST_D86: begin
        alu_req.a = tfd_pkg::OPND_W'(taps.w8);
        alu_req.b = tfd_pkg::OPND_W'(taps.w6);
        abs_nxt   = alu_rsp.absval[16:0];
        state_nxt = tfd_pkg::ST_C86;
      end
      tfd_pkg::ST_C86: begin
        alu_req.a = tfd_pkg::OPND_W'({2'b00, limit_r, 2'b00});
        alu_req.b = tfd_pkg::OPND_W'({1'b0, abs_r});
        ok86_nxt  = !alu_rsp.lt;
        state_nxt = tfd_pkg::ST_PROC;
      end
      tfd_pkg::ST_PROC: begin
        alu_req.a   = tfd_pkg::OPND_W'(proc_r);
        alu_req.b   = tfd_pkg::OPND_W'(proc_thr);
        proc_ok_nxt = !alu_rsp.lt;
        state_nxt   = tfd_pkg::ST_FIN;
      end
      tfd_pkg::ST_FIN: begin
        // Commit only once the result register can take the new result.
        if (out_free) begin
          fatal_nxt     = f_fin;
          forgive_nxt   = fl_fin;
          out_nxt       = {fl_fin, f_fin, pers_fin, fault_fin};
          out_valid_nxt = 1'b1;
          state_nxt     = tfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tfd_pkg::ST_IDLE;
      settle_r    <= '0;
      settled_r   <= 1'b0;
      idx_r       <= '0;
      fatal_r     <= '0;
      forgive_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      settle_r    <= settle_nxt;
      settled_r   <= settled_nxt;
      idx_r       <= idx_nxt;
      fatal_r     <= fatal_nxt;
      forgive_r   <= forgive_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scratch registers need no reset.
  always_ff @(posedge clk) begin
    stack_r   <= stack_nxt;
    proc_r    <= proc_nxt;
    off_r     <= off_nxt;
    good_r    <= good_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    span_r    <= span_nxt;
    over_r    <= over_nxt;
    abs_r     <= abs_nxt;
    ok89_r    <= ok89_nxt;
    ok86_r    <= ok86_nxt;
    proc_ok_r <= proc_ok_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ===== verif/fault_verdict_checker.sv =====
`timescale 1ns / 1ps

module fault_verdict_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [39:0]                    in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    failures,
  output int unsigned                    outstanding
);

  // Result fields from bit 0 upwards: fault_now, persist_request, fatal_flags,
  // transient_forgiven.
  typedef struct packed {
    logic       transient_forgiven;
    logic [1:0] fatal_flags;
    logic       persist_request;
    logic       fault_now;
  } health_t;

  tfd_pkg::temp_t stack_hist[tfd_pkg::WIN_DEPTH];
  logic [3:0]  fill_cnt;
  logic [4:0]  settle_cnt;
  logic        forgive;
  logic [1:0]  fatal;
  logic [7:0]  var_limit;
  logic [9:0]  proc_setpoint;
  logic [7:0]  startup_temp;
  health_t     expected_verdicts[$];
  int unsigned mismatches = 0;

  function automatic int distance(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic clear_model();
    fill_cnt      = '0;
    settle_cnt    = '0;
    forgive       = 1'b0;
    fatal         = '0;
    var_limit     = tfd_pkg::LIMIT_RESET;
    proc_setpoint = '0;
    startup_temp  = '0;
    expected_verdicts.delete();
  endtask

  // Works out the verdict for one stack/processor reading and moves the
  // window, counters and sticky flags on by one sample.
  task automatic assess_sample(input tfd_pkg::temp_t stack, input tfd_pkg::temp_t proc,
                               input logic off, input logic good,
                               output health_t verdict);
    int         lim;
    int         lo;
    int         hi;
    int         deg;
    int         k;
    logic [1:0] sel;
    sel     = good ? tfd_pkg::BIT_GOOD : tfd_pkg::BIT_NOT_GOOD;
    verdict = '0;
    if (off) settle_cnt = '0;
    if (fill_cnt >= tfd_pkg::WIN_DEPTH) begin
      for (k = 0; k < tfd_pkg::WIN_DEPTH - 1; k++) stack_hist[k] = stack_hist[k + 1];
      stack_hist[tfd_pkg::WIN_DEPTH - 1] = stack;
      if (settle_cnt < tfd_pkg::SETTLE_TARGET) settle_cnt++;
    end else begin
      stack_hist[fill_cnt] = stack;
      fill_cnt++;
    end
    if (settle_cnt >= tfd_pkg::SETTLE_TARGET) begin
      // Spread over the eight oldest entries, in whole degrees towards zero.
      lim = int'(var_limit);
      lo  = int'(stack_hist[0]) / 16;
      hi  = lo;
      for (k = 1; k < tfd_pkg::SPAN_COUNT; k++) begin
        deg = int'(stack_hist[k]) / 16;
        if (deg < lo) lo = deg;
        if (deg > hi) hi = deg;
      end
      if (hi - lo > lim) begin
        if (forgive) begin
          forgive = 1'b0;
        end else if (distance(stack_hist[8], stack_hist[9]) <= 2 * lim &&
                     distance(stack_hist[8], stack_hist[6]) <= 4 * lim) begin
          forgive = 1'b1;
        end
        if (!forgive) begin
          fatal                   = fatal | sel;
          verdict.persist_request = 1'b1;
          verdict.fault_now       = 1'b1;
        end
      end
      // A stack sensor that reads near zero while the processor is hot.
      if (int'(proc) >= 16 * (int'(proc_setpoint) - int'(tfd_pkg::SETPOINT_MARGIN)) &&
          stack <= tfd_pkg::NEAR_ZERO_UNITS && fatal == '0 &&
          startup_temp > tfd_pkg::MIN_START_TEMP &&
          stack_hist[6] <= tfd_pkg::NEAR_ZERO_UNITS &&
          stack_hist[7] <= tfd_pkg::NEAR_ZERO_UNITS &&
          stack_hist[8] <= tfd_pkg::NEAR_ZERO_UNITS &&
          stack_hist[9] <= tfd_pkg::NEAR_ZERO_UNITS) begin
        fatal = fatal | sel;
        if ((fatal & tfd_pkg::BIT_NOT_GOOD) == '0) verdict.persist_request = 1'b1;
        verdict.fault_now = 1'b1;
      end
    end
    verdict.fatal_flags        = fatal;
    verdict.transient_forgiven = forgive;
  endtask

  task automatic check_field(input string field, input int want, input int got,
                             inout bit bad);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    health_t verdict;
    health_t seen;
    bit      bad;
    if (!rst_n) begin
      clear_model();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = health_t'(out_tdata[4:0]);
        if (expected_verdicts.size() == 0) begin
          $display("%0t ns: result expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          verdict = expected_verdicts.pop_front();
          bad     = 1'b0;
          check_field("fault_now", verdict.fault_now, seen.fault_now, bad);
          check_field("persist_request", verdict.persist_request, seen.persist_request, bad);
          check_field("fatal_flags", verdict.fatal_flags, seen.fatal_flags, bad);
          check_field("transient_forgiven", verdict.transient_forgiven,
                      seen.transient_forgiven, bad);
          if (bad) mismatches++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tfd_pkg::REG_VARIATION_LIMIT: var_limit     = cfg_data[7:0];
          tfd_pkg::REG_PROC_SETPOINT:   proc_setpoint = cfg_data[9:0];
          tfd_pkg::REG_STARTUP_TEMP:    startup_temp  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        assess_sample(tfd_pkg::temp_t'(in_tdata[15:0]), tfd_pkg::temp_t'(in_tdata[31:16]),
                      in_tdata[32], in_tdata[33], verdict);
        expected_verdicts.push_back(verdict);
      end
    end
    failures    <= mismatches;
    outstanding <= expected_verdicts.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Index 3 has no register behind it; writes there must leave everything alone.
  localparam logic [tfd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // Each of about a thousand transfers can stall on both sides as well as wait for
  // the sequencer; the limit leaves a wide margin for that.
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned TRAIL_CYCLES  = 40;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  // tdata from bit 0: stack_temp[15:0], processor_temp[31:16], plant_off[32],
  // plant_good[33], zeros[39:34].
  logic [39:0]                    in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  // tdata from bit 0: fault_now[0], persist_request[1], fatal_flags[3:2],
  // transient_forgiven[4], zeros[7:5].
  logic [7:0]                     out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                    failures;
  int unsigned                    outstanding;
  int unsigned                    cycle_count = 0;
  bit                             in_calm = 1'b0;

  thermocouple_fault_detector_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // The checker watches every transfer on all three channels, keeps its own
  // copy of the detector state and compares each result with its prediction.
  fault_verdict_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake must not leave the run spinning forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("thermocouple_fault_detector_unit regression: fail");
      $finish;
    end
  end

  // Result side. Before each transfer ready may drop for a random stall, except during
  // calm stretches where ready simply stays high.
  initial begin : result_sink
    int stall;
    bit calm;
    calm       = 1'b0;
    out_tready = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 6);
      @(negedge clk);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic tfd_pkg::temp_t clamp_temp(input int v);
    if (v > 32767) return tfd_pkg::temp_t'(16'h7fff);
    if (v < -32768) return tfd_pkg::temp_t'(16'h8000);
    return tfd_pkg::temp_t'(v);
  endfunction

  // Offers one sample and holds it until the transfer has taken place. Valid is
  // only lowered when a gap is drawn, so back-to-back samples keep it high.
  task automatic send_reading(input tfd_pkg::temp_t stack, input tfd_pkg::temp_t proc,
                              input logic off, input logic good);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, good, off, proc, stack};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering samples and waits until the checker has seen every result.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [tfd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tfd_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stack readings close to zero, either side of the 80-unit threshold, with the
  // processor reading straddling its setpoint less the five-degree margin.
  task automatic near_zero_run(input int count, input int setpoint);
    int k;
    int thresh;
    thresh = 16 * (setpoint - 5);
    for (k = 0; k < count; k++) begin
      send_reading(clamp_temp(int'($urandom_range(0, 128)) - 32),
                   clamp_temp(thresh + int'($urandom_range(0, 96)) - 48),
                   1'b0, $urandom_range(0, 1) == 1);
    end
  endtask

  // Mostly a steady stack temperature with noise of the given amplitude. Single
  // spikes and level steps larger than the limit provoke the spread check; flat
  // neighbours around a spike let the single transient be forgiven. A few
  // samples are pure noise, and now and then the plant switches off mid-run.
  task automatic drift_run(input int count, input int lim, input int amp,
                           input int setpoint);
    int k;
    int r;
    int level;
    int jump;
    int v;
    level = int'($urandom_range(0, 60000)) - 30000;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_reading(tfd_pkg::temp_t'($urandom), tfd_pkg::temp_t'($urandom),
                     $urandom_range(0, 5) == 0, $urandom_range(0, 1) == 1);
      end else begin
        jump = 16 * lim + 16 + int'($urandom_range(0, 48 * lim));
        if (r < 10) level = int'(clamp_temp(level + ((r == 8) ? jump : -jump)));
        v = level + int'($urandom_range(0, 2 * amp)) - amp;
        if (r >= 94) v = v + ((r % 2 == 0) ? jump : -jump);
        send_reading(clamp_temp(v),
                     clamp_temp(16 * setpoint + int'($urandom_range(0, 320)) - 160),
                     $urandom_range(0, 99) == 0, $urandom_range(0, 1) == 1);
      end
    end
  endtask

  initial begin : stimulus
    int p;
    int lim;
    int amp;
    int setpoint;
    int startup;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes and alternating bit patterns before the detector has settled,
    // with both plant flags in either state and readings around the near-zero
    // threshold and the whole-degree boundaries of negative values.
    send_reading(tfd_pkg::temp_t'(16'h0000), tfd_pkg::temp_t'(16'h0000), 1'b0, 1'b0);
    send_reading(tfd_pkg::temp_t'(16'h7fff), tfd_pkg::temp_t'(16'h7fff), 1'b0, 1'b1);
    send_reading(tfd_pkg::temp_t'(16'h8000), tfd_pkg::temp_t'(16'h8000), 1'b0, 1'b0);
    send_reading(tfd_pkg::temp_t'(16'hffff), tfd_pkg::temp_t'(16'hffff), 1'b1, 1'b1);
    send_reading(tfd_pkg::temp_t'(16'h5555), tfd_pkg::temp_t'(16'haaaa), 1'b0, 1'b1);
    send_reading(tfd_pkg::temp_t'(16'haaaa), tfd_pkg::temp_t'(16'h5555), 1'b1, 1'b0);
    send_reading(tfd_pkg::temp_t'(16'h0050), tfd_pkg::temp_t'(16'h0000), 1'b0, 1'b1);
    send_reading(tfd_pkg::temp_t'(16'h0051), tfd_pkg::temp_t'(16'h7fff), 1'b0, 1'b0);
    send_reading(tfd_pkg::temp_t'(16'hfff0), tfd_pkg::temp_t'(16'h8000), 1'b0, 1'b1);
    send_reading(tfd_pkg::temp_t'(16'hfff1), tfd_pkg::temp_t'(16'h0001), 1'b0, 1'b0);
    send_reading(tfd_pkg::temp_t'(16'h000f), tfd_pkg::temp_t'(16'hffff), 1'b0, 1'b1);
    send_reading(tfd_pkg::temp_t'(16'h0010), tfd_pkg::temp_t'(16'h0010), 1'b1, 1'b0);
    send_reading(tfd_pkg::temp_t'(16'hffef), tfd_pkg::temp_t'(16'h0050), 1'b0, 1'b1);
    send_reading(tfd_pkg::temp_t'(16'h8001), tfd_pkg::temp_t'(16'h7ffe), 1'b0, 1'b0);
    send_reading(tfd_pkg::temp_t'(16'h7ffe), tfd_pkg::temp_t'(16'h8001), 1'b0, 1'b1);
    send_reading(tfd_pkg::temp_t'(16'h0000), tfd_pkg::temp_t'(16'h0000), 1'b1, 1'b0);
    drain();

    // The fatal bits can only be cleared by reset, so the stuck-sensor check is
    // exercised first, before any spread fault. With the start temperature at
    // exactly 10 it must stay silent; at 11 it may fire once. The wide limit
    // keeps the spread check quiet. The upper data bits are set on purpose: the
    // 8-bit registers must ignore them.
    setpoint = $urandom_range(0, 40);
    write_register(tfd_pkg::REG_VARIATION_LIMIT, 10'h3ff);
    write_register(tfd_pkg::REG_PROC_SETPOINT, 10'(setpoint));
    write_register(tfd_pkg::REG_STARTUP_TEMP, {2'b11, 8'(tfd_pkg::MIN_START_TEMP)});
    near_zero_run(40, setpoint);
    drain();
    write_register(tfd_pkg::REG_STARTUP_TEMP, 10'(int'(tfd_pkg::MIN_START_TEMP) + 1));
    near_zero_run(60, setpoint);
    drain();

    // Spread phases. The first four pin the limit at 0, 255, 1 and the reset value;
    // the rest draw it at random. Each phase ends with the sender waiting for every
    // outstanding result, so registers only change while idle.
    for (p = 0; p < 8; p++) begin
      case (p)
        0:       lim = 0;
        1:       lim = 255;
        2:       lim = 1;
        3:       lim = int'(tfd_pkg::LIMIT_RESET);
        default: lim = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 3))
        0:       amp = 0;
        1:       amp = 2 * lim;
        2:       amp = 8 * lim + 8;
        default: amp = 40;
      endcase
      setpoint = (p == 0) ? 1023 : (p == 1) ? 0 : $urandom_range(0, 1023);
      startup  = (p == 0) ? 255 : (p == 1) ? 0 : $urandom_range(0, 255);
      write_register(tfd_pkg::REG_VARIATION_LIMIT, {2'($urandom_range(0, 3)), 8'(lim)});
      write_register(tfd_pkg::REG_PROC_SETPOINT, 10'(setpoint));
      write_register(tfd_pkg::REG_STARTUP_TEMP, {2'($urandom_range(0, 3)), 8'(startup)});
      if (p % 3 == 0) write_register(REG_SPARE, 10'($urandom));
      drift_run(105, lim, amp, setpoint);
      drain();
    end

    // Give the block time to show any result that nobody asked for.
    repeat (TRAIL_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("thermocouple_fault_detector_unit regression: pass");
    end else begin
      $display("thermocouple_fault_detector_unit regression: fail");
    end
    $finish;
  end

endmodule
